### rtl/dnsx_pkg.sv
`default_nettype none

package dnsx_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned CNT_W   = 16;

  localparam logic [15:0] RESP_BIT   = 16'h8000;
  localparam logic [15:0] RCODE_MASK = 16'h000F;
  localparam logic [7:0]  PTR_MASK   = 8'hC0;
  localparam logic [7:0]  MAX_LABEL  = 8'd63;
  localparam logic [15:0] HEADER_LAST = 16'd11;
  localparam logic [15:0] FIXED_LAST  = 16'd9;
  localparam logic [15:0] ADDR_LAST   = 16'd3;
  localparam logic [15:0] QTAIL_LEN   = 16'd4;
  localparam logic [15:0] TYPE_A      = 16'd1;
  localparam logic [15:0] A_DLEN      = 16'd4;

  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_PREFIX = 4'd1,
    PH_HEADER = 4'd2,
    PH_QLEN   = 4'd3,
    PH_QSKIP  = 4'd4,
    PH_QTAIL  = 4'd5,
    PH_ANAME  = 4'd6,
    PH_APTR   = 4'd7,
    PH_ALEN   = 4'd8,
    PH_ASKIP  = 4'd9,
    PH_FIXED  = 4'd10,
    PH_RSKIP  = 4'd11,
    PH_ADDR   = 4'd12,
    PH_DONE   = 4'd13
  } phase_t;

  typedef struct packed {
    logic              valid;
    logic              found;
    logic [ADDR_W-1:0] addr;
  } result_t;

endpackage

`default_nettype wire

### rtl/dnsx_parser.sv
`default_nettype none

module dnsx_parser (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step_en,
  input  wire logic [dnsx_pkg::BYTE_W-1:0]  pkt_byte,
  input  wire logic                         last,
  input  wire logic                         tcp_framing,
  output dnsx_pkg::result_t                 res
);

  dnsx_pkg::phase_t                  phase_r, phase_nxt;
  logic [dnsx_pkg::CNT_W-1:0]        skip_r, skip_nxt;
  logic [dnsx_pkg::CNT_W-1:0]        answers_r, answers_nxt;
  logic [dnsx_pkg::ADDR_W-1:0]       shift_r, shift_nxt;
  logic [dnsx_pkg::CNT_W-1:0]        rtype_r, rtype_nxt;
  logic                              given_r, given_nxt;

  logic [dnsx_pkg::CNT_W-1:0]        skip_dec;
  logic [dnsx_pkg::CNT_W-1:0]        skip_inc;
  logic [dnsx_pkg::CNT_W-1:0]        ans_dec;
  logic [dnsx_pkg::CNT_W-1:0]        shift16;
  logic [dnsx_pkg::ADDR_W-1:0]       shift32;
  logic [dnsx_pkg::CNT_W-1:0]        fix_type;
  logic [dnsx_pkg::CNT_W-1:0]        fix_len;
  logic [dnsx_pkg::CNT_W-1:0]        hdr_flags;
  logic [dnsx_pkg::CNT_W-1:0]        hdr_ans;
  logic                              hit;
  logic                              is_ptr;

  assign skip_dec = skip_r - 16'd1;
  assign skip_inc = skip_r + 16'd1;
  assign ans_dec  = answers_r - 16'd1;
  assign shift16  = {shift_r[7:0], pkt_byte};
  assign shift32  = {shift_r[23:0], pkt_byte};
  assign is_ptr   = (pkt_byte & dnsx_pkg::PTR_MASK) == dnsx_pkg::PTR_MASK;

  always_comb begin
    hdr_flags = shift_r[15:0];
    hdr_ans   = answers_r;
    if (skip_r == 16'd2 || skip_r == 16'd3) begin
      hdr_flags = shift16;
    end
    if (skip_r == 16'd6 || skip_r == 16'd7) begin
      hdr_ans = {answers_r[7:0], pkt_byte};
    end
    fix_type = rtype_r;
    fix_len  = shift_r[15:0];
    if (skip_r < 16'd2) begin
      fix_type = {rtype_r[7:0], pkt_byte};
    end
    if (skip_r == 16'd8 || skip_r == 16'd9) begin
      fix_len = shift16;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    skip_nxt    = skip_r;
    answers_nxt = answers_r;
    shift_nxt   = shift_r;
    rtype_nxt   = rtype_r;
    given_nxt   = given_r;
    hit         = 1'b0;
    case (phase_r)
      dnsx_pkg::PH_START: begin
        answers_nxt = '0;
        rtype_nxt   = '0;
        shift_nxt   = '0;
        if (tcp_framing) begin
          skip_nxt  = 16'd1;
          phase_nxt = dnsx_pkg::PH_PREFIX;
        end else begin
          skip_nxt  = 16'd1;
          phase_nxt = dnsx_pkg::PH_HEADER;
        end
      end
      dnsx_pkg::PH_PREFIX: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = dnsx_pkg::PH_HEADER;
        end
      end
      dnsx_pkg::PH_HEADER: begin
        shift_nxt   = {16'd0, hdr_flags};
        answers_nxt = hdr_ans;
        skip_nxt    = skip_inc;
        if (skip_r >= dnsx_pkg::HEADER_LAST) begin
          if ((hdr_flags & dnsx_pkg::RESP_BIT) == '0 ||
              (hdr_flags & dnsx_pkg::RCODE_MASK) != '0 || hdr_ans == '0) begin
            phase_nxt = dnsx_pkg::PH_DONE;
          end else begin
            phase_nxt = dnsx_pkg::PH_QLEN;
          end
        end
      end
      dnsx_pkg::PH_QLEN: begin
        if (pkt_byte == '0) begin
          skip_nxt  = dnsx_pkg::QTAIL_LEN;
          phase_nxt = dnsx_pkg::PH_QTAIL;
        end else if (pkt_byte > dnsx_pkg::MAX_LABEL) begin
          phase_nxt = dnsx_pkg::PH_DONE;
        end else begin
          skip_nxt  = {8'd0, pkt_byte};
          phase_nxt = dnsx_pkg::PH_QSKIP;
        end
      end
      dnsx_pkg::PH_QSKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = dnsx_pkg::PH_QLEN;
        end
      end
      dnsx_pkg::PH_QTAIL: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = dnsx_pkg::PH_ANAME;
        end
      end
      dnsx_pkg::PH_ANAME, dnsx_pkg::PH_ALEN: begin
        if (phase_r == dnsx_pkg::PH_ANAME && is_ptr) begin
          phase_nxt = dnsx_pkg::PH_APTR;
        end else if (pkt_byte == '0) begin
          phase_nxt = dnsx_pkg::PH_FIXED;
          skip_nxt  = '0;
          rtype_nxt = '0;
          shift_nxt = '0;
        end else if (pkt_byte > dnsx_pkg::MAX_LABEL) begin
          phase_nxt = dnsx_pkg::PH_DONE;
        end else begin
          skip_nxt  = {8'd0, pkt_byte};
          phase_nxt = dnsx_pkg::PH_ASKIP;
        end
      end
      dnsx_pkg::PH_APTR: begin
        phase_nxt = dnsx_pkg::PH_FIXED;
        skip_nxt  = '0;
        rtype_nxt = '0;
        shift_nxt = '0;
      end
      dnsx_pkg::PH_ASKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = dnsx_pkg::PH_ALEN;
        end
      end
      dnsx_pkg::PH_FIXED: begin
        rtype_nxt = fix_type;
        shift_nxt = {16'd0, fix_len};
        skip_nxt  = skip_inc;
        if (skip_r >= dnsx_pkg::FIXED_LAST) begin
          if (fix_type == dnsx_pkg::TYPE_A && fix_len == dnsx_pkg::A_DLEN) begin
            phase_nxt = dnsx_pkg::PH_ADDR;
            skip_nxt  = '0;
            shift_nxt = '0;
          end else if (fix_len == '0) begin
            answers_nxt = ans_dec;
            phase_nxt   = (ans_dec == '0) ? dnsx_pkg::PH_DONE : dnsx_pkg::PH_ANAME;
          end else begin
            skip_nxt  = fix_len;
            phase_nxt = dnsx_pkg::PH_RSKIP;
          end
        end
      end
      dnsx_pkg::PH_RSKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          answers_nxt = ans_dec;
          phase_nxt   = (ans_dec == '0) ? dnsx_pkg::PH_DONE : dnsx_pkg::PH_ANAME;
        end
      end
      dnsx_pkg::PH_ADDR: begin
        shift_nxt = shift32;
        skip_nxt  = skip_inc;
        if (skip_r >= dnsx_pkg::ADDR_LAST) begin
          hit       = 1'b1;
          given_nxt = 1'b1;
          phase_nxt = dnsx_pkg::PH_DONE;
        end
      end
      default: begin
        phase_nxt = dnsx_pkg::PH_DONE;
      end
    endcase
    if (last) begin
      phase_nxt = dnsx_pkg::PH_START;
      given_nxt = 1'b0;
    end
  end

  // header byte at packet start without framing: flags/count indices are never 0
  always_comb begin
    res.valid = hit || (last && !given_r);
    res.found = hit;
    res.addr  = hit ? shift32 : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= dnsx_pkg::PH_START;
      skip_r    <= '0;
      answers_r <= '0;
      shift_r   <= '0;
      rtype_r   <= '0;
      given_r   <= 1'b0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      skip_r    <= skip_nxt;
      answers_r <= answers_nxt;
      shift_r   <= shift_nxt;
      rtype_r   <= rtype_nxt;
      given_r   <= given_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/dns_response_ipv4_extractor.sv
// Path: a byte is held in the input register and its result in the result register before the result transfer.
// Throughput: one byte per cycle unless a result is blocked at the output; the parser state advances once per byte.
// A byte waits in the input register only while a result it produces is blocked at the output.
// Reset (rst_n low, synchronous): parser returns to packet start, framing off, both stages empty.
`default_nettype none

module dns_response_ipv4_extractor (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [dnsx_pkg::BYTE_W-1:0]   in_packet_byte,
  input  wire logic                          in_last_byte,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic                          out_found,
  output      logic [dnsx_pkg::ADDR_W-1:0]   out_ipv4_address,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic                          cfg_tcp_framing
);

  logic                            tcp_framing_r;
  logic                            s1_valid_r;
  logic [dnsx_pkg::BYTE_W-1:0]     s1_byte_r;
  logic                            s1_last_r;
  logic                            out_valid_r;
  logic                            out_found_r;
  logic [dnsx_pkg::ADDR_W-1:0]     out_addr_r;
  logic                            out_free;
  logic                            s1_go;
  dnsx_pkg::result_t               res;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && (!res.valid || out_free);
  assign in_stall  = s1_valid_r && !s1_go;

  dnsx_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (s1_go),
    .pkt_byte    (s1_byte_r),
    .last        (s1_last_r),
    .tcp_framing (tcp_framing_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcp_framing_r <= 1'b0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tcp_framing_r <= cfg_tcp_framing;
      end
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_go && res.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_packet_byte;
      s1_last_r <= in_last_byte;
    end
    if (out_free && s1_go && res.valid) begin
      out_found_r <= res.found;
      out_addr_r  <= res.addr;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_ipv4_address = out_addr_r;

endmodule

`default_nettype wire
